[sv/oscillator_neighbor_coupling_core_assert.svh]
// Assertion macros shared by the coupling core. Both sample on clk and are
// switched off while rst_n is low.
`ifndef OSCILLATOR_NEIGHBOR_COUPLING_CORE_ASSERT_SVH
`define OSCILLATOR_NEIGHBOR_COUPLING_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the condition.
`define ONC_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The consequent must hold in the cycle after the condition.
`define ONC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/onc_pkg.sv]
package onc_pkg;

    localparam int IDX_W       = 6;
    localparam int PHASE_W     = 16;
    localparam int COORD_W     = 3;
    localparam int TOPO_W      = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int STORE_DEPTH = 64;
    localparam int SLOTS       = 8;
    localparam int SLOT_W      = 3;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = 16'h8000;
    localparam logic [PHASE_W-1:0] STEP_RESET = 16'd328;

    // Input item modes.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FIRE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_TOPOLOGY      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUPLING_STEP = 1'b1;

    // Topology codes.
    localparam logic [TOPO_W-1:0] TOPO_FOUR_BOUNDED  = 3'd0;
    localparam logic [TOPO_W-1:0] TOPO_FOUR_TORUS    = 3'd1;
    localparam logic [TOPO_W-1:0] TOPO_EIGHT_BOUNDED = 3'd2;
    localparam logic [TOPO_W-1:0] TOPO_EIGHT_TORUS   = 3'd3;
    localparam logic [TOPO_W-1:0] TOPO_GLOBAL        = 3'd4;

    // Neighbour slots in visiting order: right, down-right, left, up-left,
    // down, down-left, up, up-right. Bit s of each mask describes slot s.
    localparam logic [SLOTS-1:0] SLOT_COL_RIGHT = 8'b1000_0011;
    localparam logic [SLOTS-1:0] SLOT_COL_LEFT  = 8'b0010_1100;
    localparam logic [SLOTS-1:0] SLOT_ROW_DOWN  = 8'b0011_0010;
    localparam logic [SLOTS-1:0] SLOT_ROW_UP    = 8'b1100_1000;
    localparam logic [SLOTS-1:0] SLOT_DIAGONAL  = 8'b1010_1010;

    typedef struct packed {
        logic write_item;
        logic load;
        logic issue;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic item_write;
        logic item_fire;
        logic issue_last;
    } status_t;

endpackage

[sv/oscillator_neighbor_coupling_core.sv]
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+----------------------------------
// item     | start, busy (taken: start&!busy) | mode, osc_index, phase_value
// result   | result_valid (one-cycle strobe)  | target_index, new_phase, last
// config   | cfg_valid, cfg_ready             | cfg_index, cfg_data
//
// A write item never raises busy; its echo appears in the cycle after the transaction.
// A fire item keeps busy high while its n neighbour updates issue and write back, one
// update per cycle through the single read and write port of the phase memory: up to
// eight in eight-way modes, four in four-way modes, OscCount - 1 in global mode.
// Each result is strobed in the cycle after its write-back; results cannot be stalled.
// Reset clears all phases through per-entry valid bits, with no clearing pass.
`include "oscillator_neighbor_coupling_core_assert.svh"

module oscillator_neighbor_coupling_core #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            mode,
    input  logic [onc_pkg::IDX_W-1:0]       osc_index,
    input  logic [onc_pkg::PHASE_W-1:0]     phase_value,
    output logic                            result_valid,
    output logic [onc_pkg::IDX_W-1:0]       target_index,
    output logic [onc_pkg::PHASE_W-1:0]     new_phase,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [onc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [onc_pkg::PHASE_W-1:0]     cfg_data
);

    onc_pkg::cmd_t    cmd;
    onc_pkg::status_t sts;

    // Registers take a write only while no item is offered or in progress.
    assign cfg_ready = !busy && !start;

    onc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    onc_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .osc_index    (osc_index),
        .phase_value  (phase_value),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .target_index (target_index),
        .new_phase    (new_phase),
        .last         (last)
    );

    `ONC_ASSERT_NEXT(a_write_echo, start && !busy && sts.item_write, result_valid && last && (target_index == $past(osc_index)), "write transaction gave no echo")
    `ONC_ASSERT_NOW(a_fire_closes, $fell(busy), result_valid && last, "fire ended without a final result")
    `ONC_ASSERT_NOW(a_mid_result, result_valid && !last, busy, "non-final result outside a fire")
    `ONC_ASSERT_NOW(a_phase_range, result_valid, new_phase <= onc_pkg::PHASE_ONE, "result phase above one")

endmodule

[sv/onc_ctrl.sv]
module onc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  onc_pkg::status_t sts,
    output onc_pkg::cmd_t    cmd,
    output logic             busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       upd_reg;
    logic       upd_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.item_fire)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (sts.issue_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A neighbour read in one cycle is written back in the next.
    assign upd_next = (state_reg == ST_ISSUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            upd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upd_reg   <= upd_next;
        end
    end

    assign cmd.write_item = accept && sts.item_write;
    assign cmd.load       = accept && sts.item_fire;
    assign cmd.issue      = (state_reg == ST_ISSUE);
    assign cmd.update     = upd_reg;
    assign busy           = (state_reg != ST_IDLE);

endmodule

[sv/onc_datapath.sv]
module onc_datapath #(
    parameter int GRID_WIDTH,
    parameter int GRID_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  onc_pkg::cmd_t                       cmd,
    output onc_pkg::status_t                    sts,
    input  logic                                mode,
    input  logic [onc_pkg::IDX_W-1:0]           osc_index,
    input  logic [onc_pkg::PHASE_W-1:0]         phase_value,
    input  logic                                cfg_valid,
    input  logic [onc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [onc_pkg::PHASE_W-1:0]         cfg_data,
    output logic                                result_valid,
    output logic [onc_pkg::IDX_W-1:0]           target_index,
    output logic [onc_pkg::PHASE_W-1:0]         new_phase,
    output logic                                last
);

    localparam int IdxW   = onc_pkg::IDX_W;
    localparam int CntW   = onc_pkg::IDX_W + 1;
    localparam int PhaseW = onc_pkg::PHASE_W;
    localparam int CoordW = onc_pkg::COORD_W;
    localparam int TopoW  = onc_pkg::TOPO_W;
    localparam int SlotW  = onc_pkg::SLOT_W;
    localparam int Slots  = onc_pkg::SLOTS;
    localparam int Depth  = onc_pkg::STORE_DEPTH;
    localparam int OscCount = GRID_WIDTH * GRID_HEIGHT;

    localparam logic [CoordW-1:0] ColMax     = CoordW'(GRID_WIDTH - 1);
    localparam logic [CoordW-1:0] RowMax     = CoordW'(GRID_HEIGHT - 1);
    localparam logic [IdxW-1:0]   IdxLast    = IdxW'(OscCount - 1);
    localparam logic [IdxW-1:0]   IdxPenult  = IdxW'(OscCount - 2);

    // Configuration.
    logic [TopoW-1:0]  topology_reg;
    logic [PhaseW-1:0] step_reg;

    // Decoding of the offered item.
    logic [CntW-1:0]   idx_ext;
    logic              in_grid;
    logic [CoordW-1:0] row_in;
    logic [CoordW-1:0] col_in;
    logic [Slots-1:0]  mask_in;
    logic              wrap;
    logic              eight;
    logic              edge_ok;

    // Fire context.
    logic [IdxW-1:0]   idx_reg;
    logic [CoordW-1:0] row_reg;
    logic [CoordW-1:0] col_reg;
    logic [Slots-1:0]  mask_reg;
    logic              global_reg;
    logic [IdxW-1:0]   cursor_reg;
    logic [IdxW-1:0]   glast_reg;

    // Target selection.
    logic [SlotW-1:0]  slot;
    logic [Slots-1:0]  mask_rest;
    logic [CoordW-1:0] tgt_row;
    logic [CoordW-1:0] tgt_col;
    logic [IdxW-1:0]   grid_tgt;
    logic [IdxW-1:0]   tgt;
    logic [IdxW-1:0]   cursor_step;

    // Read-modify-write.
    logic [IdxW-1:0]   upd_tgt_reg;
    logic              upd_last_reg;
    logic [PhaseW-1:0] rd_data_reg;
    logic [PhaseW:0]   sum;
    logic [PhaseW-1:0] sat_sum;
    logic [PhaseW-1:0] clamp;
    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    logic [PhaseW-1:0] wr_data;
    logic [PhaseW-1:0] phase_mem_reg [Depth];
    logic [Depth-1:0]  valid_reg;

    // Results.
    logic              result_valid_reg;
    logic [IdxW-1:0]   target_reg;
    logic [PhaseW-1:0] phase_reg;
    logic              last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg <= onc_pkg::TOPO_FOUR_BOUNDED;
            step_reg     <= onc_pkg::STEP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                onc_pkg::CFG_TOPOLOGY:      topology_reg <= cfg_data[TopoW-1:0];
                onc_pkg::CFG_COUPLING_STEP: step_reg     <= cfg_data;
            endcase
        end
    end

    assign idx_ext = {1'b0, osc_index};
    assign in_grid = (idx_ext < CntW'(OscCount));

    assign sts.item_write = (mode == onc_pkg::MODE_WRITE) && in_grid;
    assign sts.item_fire  = (mode == onc_pkg::MODE_FIRE) && in_grid
                            && (topology_reg <= onc_pkg::TOPO_GLOBAL);

    // Row is the number of full grid rows below the index.
    always_comb
    begin
        row_in = '0;
        for (int k = 1; k < GRID_HEIGHT; k++)
        begin
            if (idx_ext >= CntW'(k * GRID_WIDTH))
            begin
                row_in = CoordW'(k);
            end
        end
    end

    assign col_in = CoordW'(osc_index - IdxW'(row_in * GRID_WIDTH));

    assign wrap  = (topology_reg == onc_pkg::TOPO_FOUR_TORUS)
                   || (topology_reg == onc_pkg::TOPO_EIGHT_TORUS);
    assign eight = (topology_reg == onc_pkg::TOPO_EIGHT_BOUNDED)
                   || (topology_reg == onc_pkg::TOPO_EIGHT_TORUS);

    always_comb
    begin
        edge_ok = 1'b0;
        for (int s = 0; s < Slots; s++)
        begin
            edge_ok = (!onc_pkg::SLOT_COL_RIGHT[s] || (col_in != ColMax))
                      && (!onc_pkg::SLOT_COL_LEFT[s] || (col_in != '0))
                      && (!onc_pkg::SLOT_ROW_DOWN[s] || (row_in != RowMax))
                      && (!onc_pkg::SLOT_ROW_UP[s] || (row_in != '0));
            mask_in[s] = (eight || !onc_pkg::SLOT_DIAGONAL[s]) && (wrap || edge_ok);
        end
    end

    // Lowest pending slot is visited first.
    always_comb
    begin
        slot = '0;
        for (int s = Slots - 1; s >= 0; s--)
        begin
            if (mask_reg[s])
            begin
                slot = SlotW'(s);
            end
        end
    end

    assign mask_rest = mask_reg & ~(Slots'(1) << slot);

    always_comb
    begin
        tgt_row = row_reg;
        if (onc_pkg::SLOT_ROW_DOWN[slot])
        begin
            tgt_row = (row_reg == RowMax) ? '0 : row_reg + 1'b1;
        end
        else if (onc_pkg::SLOT_ROW_UP[slot])
        begin
            tgt_row = (row_reg == '0) ? RowMax : row_reg - 1'b1;
        end
        tgt_col = col_reg;
        if (onc_pkg::SLOT_COL_RIGHT[slot])
        begin
            tgt_col = (col_reg == ColMax) ? '0 : col_reg + 1'b1;
        end
        else if (onc_pkg::SLOT_COL_LEFT[slot])
        begin
            tgt_col = (col_reg == '0) ? ColMax : col_reg - 1'b1;
        end
    end

    assign grid_tgt = IdxW'(tgt_row * GRID_WIDTH) + IdxW'(tgt_col);
    assign tgt      = global_reg ? cursor_reg : grid_tgt;

    assign sts.issue_last = global_reg ? (cursor_reg == glast_reg) : (mask_rest == '0);

    // The global sweep steps over the firing oscillator.
    assign cursor_step = ((cursor_reg + 1'b1) == idx_reg) ? cursor_reg + IdxW'(2)
                                                          : cursor_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg    <= osc_index;
            row_reg    <= row_in;
            col_reg    <= col_in;
            mask_reg   <= mask_in;
            global_reg <= (topology_reg == onc_pkg::TOPO_GLOBAL);
            cursor_reg <= (osc_index == '0) ? IdxW'(1) : '0;
            glast_reg  <= (osc_index == IdxLast) ? IdxPenult : IdxLast;
        end
        else if (cmd.issue)
        begin
            mask_reg   <= mask_rest;
            cursor_reg <= cursor_step;
        end
    end

    assign sum     = {1'b0, rd_data_reg} + {1'b0, step_reg};
    assign sat_sum = (sum > {1'b0, onc_pkg::PHASE_ONE}) ? onc_pkg::PHASE_ONE
                                                        : sum[PhaseW-1:0];
    assign clamp   = (phase_value > onc_pkg::PHASE_ONE) ? onc_pkg::PHASE_ONE : phase_value;

    assign wr_en   = cmd.write_item || cmd.update;
    assign wr_addr = cmd.update ? upd_tgt_reg : osc_index;
    assign wr_data = cmd.update ? sat_sum : clamp;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            phase_mem_reg[wr_addr] <= wr_data;
        end
    end

    // A read of the entry being written back this cycle takes the new value,
    // so a neighbour listed twice in a row sees its first bump.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            if (wr_en && (wr_addr == tgt))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= valid_reg[tgt] ? phase_mem_reg[tgt] : '0;
            end
            upd_tgt_reg  <= tgt;
            upd_last_reg <= sts.issue_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            result_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            target_reg <= wr_addr;
            phase_reg  <= wr_data;
            last_reg   <= cmd.update ? upd_last_reg : 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign target_index = target_reg;
    assign new_phase    = phase_reg;
    assign last         = last_reg;

endmodule

[tb/coupling_result_checker.sv]
module coupling_result_checker
    import onc_pkg::*;
#(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   mode,
    input  logic [IDX_W-1:0]       osc_index,
    input  logic [PHASE_W-1:0]     phase_value,
    input  logic                   result_valid,
    input  logic [IDX_W-1:0]       target_index,
    input  logic [PHASE_W-1:0]     new_phase,
    input  logic                   last,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PHASE_W-1:0]     cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    localparam int OSC_TOTAL = GRID_WIDTH * GRID_HEIGHT;

    typedef struct packed {
        logic [IDX_W-1:0]   target;
        logic [PHASE_W-1:0] phase;
        logic               final_flag;
    } phase_update_t;

    logic [PHASE_W-1:0] phase_mirror [0:STORE_DEPTH-1];
    logic [TOPO_W-1:0]  topo_setting;
    logic [PHASE_W-1:0] step_setting;
    phase_update_t      awaited_updates [$];

    // Saturating increment of one stored phase; returns the value written back.
    function automatic logic [PHASE_W-1:0] bump_phase(input int idx);
        int sum;
        begin
            sum = int'(phase_mirror[idx]) + int'(step_setting);
            if (sum > int'(PHASE_ONE))
                sum = int'(PHASE_ONE);
            phase_mirror[idx] = sum[PHASE_W-1:0];
            return sum[PHASE_W-1:0];
        end
    endfunction

    function automatic void predict_fire_updates(input int src);
        int row_off [SLOTS] = '{0, 1, 0, -1, 1, 1, -1, -1};
        int col_off [SLOTS] = '{1, 1, -1, -1, 0, -1, 0, 1};
        int targets [$];
        int row;
        int col;
        int r;
        int c;
        logic wrap;
        logic eight;
        phase_update_t upd;
        begin
            if (topo_setting == TOPO_GLOBAL)
            begin
                for (int j = 0; j < OSC_TOTAL; j++)
                    if (j != src)
                        targets.push_back(j);
            end
            else if (topo_setting < TOPO_GLOBAL)
            begin
                row   = src / GRID_WIDTH;
                col   = src % GRID_WIDTH;
                wrap  = (topo_setting == TOPO_FOUR_TORUS) ||
                        (topo_setting == TOPO_EIGHT_TORUS);
                eight = (topo_setting == TOPO_EIGHT_BOUNDED) ||
                        (topo_setting == TOPO_EIGHT_TORUS);
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (SLOT_DIAGONAL[s] && !eight)
                        continue;
                    r = row + row_off[s];
                    c = col + col_off[s];
                    if (wrap)
                    begin
                        r = (r + GRID_HEIGHT) % GRID_HEIGHT;
                        c = (c + GRID_WIDTH) % GRID_WIDTH;
                    end
                    else if (r < 0 || r >= GRID_HEIGHT || c < 0 || c >= GRID_WIDTH)
                    begin
                        continue;
                    end
                    targets.push_back(r * GRID_WIDTH + c);
                end
            end
            foreach (targets[k])
            begin
                upd.target     = targets[k][IDX_W-1:0];
                upd.phase      = bump_phase(targets[k]);
                upd.final_flag = (k == targets.size() - 1);
                awaited_updates.push_back(upd);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        phase_update_t seen;
        phase_update_t want;
        logic [PHASE_W-1:0] stored;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                phase_mirror[i] = '0;
            topo_setting = TOPO_FOUR_BOUNDED;
            step_setting = STEP_RESET;
            awaited_updates.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TOPOLOGY)
                    topo_setting = cfg_data[TOPO_W-1:0];
                else if (cfg_index == CFG_COUPLING_STEP)
                    step_setting = cfg_data;
            end

            if (result_valid)
            begin
                seen.target     = target_index;
                seen.phase      = new_phase;
                seen.final_flag = last;
                if (awaited_updates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: target %0d phase %0d last %0b",
                                 seen.target, seen.phase, seen.final_flag);
                end
                else
                begin
                    want = awaited_updates.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected target %0d phase %0d last %0b,",
                                     want.target, want.phase, want.final_flag,
                                     " got target %0d phase %0d last %0b",
                                     seen.target, seen.phase, seen.final_flag);
                    end
                end
            end

            // The predictor applies each accepted transaction in full at once.
            if (start && !busy && int'(osc_index) < OSC_TOTAL)
            begin
                if (mode == MODE_WRITE)
                begin
                    stored = (phase_value > PHASE_ONE) ? PHASE_ONE : phase_value;
                    phase_mirror[osc_index] = stored;
                    want.target     = osc_index;
                    want.phase      = stored;
                    want.final_flag = 1'b1;
                    awaited_updates.push_back(want);
                end
                else
                begin
                    predict_fire_updates(int'(osc_index));
                end
            end
            outstanding = awaited_updates.size();
        end
    end

endmodule

[tb/oscillator_neighbor_coupling_core_test.sv]
module oscillator_neighbor_coupling_core_test;
    import onc_pkg::*;

    localparam int GRID_WIDTH  = 8;
    localparam int GRID_HEIGHT = 8;
    localparam int SETTLE_CYCLES = 90;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   mode;
    logic [IDX_W-1:0]       osc_index;
    logic [PHASE_W-1:0]     phase_value;
    logic                   result_valid;
    logic [IDX_W-1:0]       target_index;
    logic [PHASE_W-1:0]     new_phase;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [PHASE_W-1:0]     cfg_data;
    int                     mismatches;
    int                     outstanding;
    logic                   gaps_on;

    oscillator_neighbor_coupling_core #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .osc_index    (osc_index),
        .phase_value  (phase_value),
        .result_valid (result_valid),
        .target_index (target_index),
        .new_phase    (new_phase),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    coupling_result_checker #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .osc_index    (osc_index),
        .phase_value  (phase_value),
        .result_valid (result_valid),
        .target_index (target_index),
        .new_phase    (new_phase),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4 * 300000);
        $display("TEST FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue_item(input logic m, input int idx, input logic [PHASE_W-1:0] pv);
        int gap;
        begin
            gap = gaps_on ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            start       = 1'b1;
            mode        = m;
            osc_index   = idx[IDX_W-1:0];
            phase_value = pv;
            do
            begin
                @(posedge clk);
            end
            while (busy);
            @(negedge clk);
        end
    endtask

    // Waits until every predicted result has arrived and the block has gone quiet.
    task automatic drain_results;
        begin
            start = 1'b0;
            while (outstanding != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic load_settings(input logic [PHASE_W-1:0] topo_word,
                                 input logic [PHASE_W-1:0] step_word);
        begin
            drain_results();
            cfg_valid = 1'b1;
            cfg_index = CFG_TOPOLOGY;
            cfg_data  = topo_word;
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            @(negedge clk);
            cfg_index = CFG_COUPLING_STEP;
            cfg_data  = step_word;
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    function automatic logic [PHASE_W-1:0] pick_phase();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PHASE_ONE;
            2:       return PHASE_ONE - 1'b1;
            3:       return PHASE_W'($urandom_range(0, 65535));
            default: return PHASE_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic int pick_index();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return GRID_WIDTH - 1;
            2:       return GRID_WIDTH * (GRID_HEIGHT - 1);
            3:       return GRID_WIDTH * GRID_HEIGHT - 1;
            default: return $urandom_range(0, GRID_WIDTH * GRID_HEIGHT - 1);
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PHASE_ONE;
            2:       return 16'hFFFF;
            3:       return PHASE_W'($urandom_range(0, 65535));
            default: return PHASE_W'($urandom_range(1, 4000));
        endcase
    endfunction

    initial
    begin
        logic [TOPO_W-1:0]  topo;
        logic [PHASE_W-1:0] topo_word;
        int                 item_count;

        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_WRITE;
        osc_index   = '0;
        phase_value = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_TOPOLOGY;
        cfg_data    = '0;
        gaps_on     = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset settings.
        issue_item(MODE_WRITE, 0, '0);
        issue_item(MODE_WRITE, 63, PHASE_ONE);
        issue_item(MODE_WRITE, 9, 16'hFFFF);
        issue_item(MODE_WRITE, 1, PHASE_ONE - 1'b1);
        issue_item(MODE_FIRE, 0, 16'hFFFF);
        issue_item(MODE_FIRE, 63, '0);
        issue_item(MODE_FIRE, 27, '0);
        issue_item(MODE_FIRE, 7, '0);
        issue_item(MODE_FIRE, 56, '0);

        load_settings(PHASE_W'(TOPO_FOUR_TORUS), 16'd1000);
        issue_item(MODE_FIRE, 0, '0);
        issue_item(MODE_FIRE, 63, '0);

        load_settings(PHASE_W'(TOPO_EIGHT_BOUNDED), '0);
        issue_item(MODE_FIRE, 0, '0);
        issue_item(MODE_FIRE, 36, '0);

        load_settings(PHASE_W'(TOPO_EIGHT_TORUS), PHASE_ONE);
        issue_item(MODE_WRITE, 10, 16'h5555);
        issue_item(MODE_FIRE, 0, '0);
        issue_item(MODE_FIRE, 63, '0);

        load_settings(PHASE_W'(TOPO_GLOBAL), 16'hFFFF);
        issue_item(MODE_FIRE, 0, '0);
        issue_item(MODE_WRITE, 5, 16'h2AAA);
        issue_item(MODE_FIRE, 63, '0);

        // Topology codes beyond global leave a fire without any update.
        load_settings(PHASE_W'(TOPO_GLOBAL + 3'd1), 16'd7);
        issue_item(MODE_FIRE, 10, '0);
        load_settings(16'hFFF8 | PHASE_W'(TOPO_GLOBAL + 3'd3), 16'd7);
        issue_item(MODE_FIRE, 20, '0);
        issue_item(MODE_WRITE, 20, 16'd123);

        // Random phases, each under its own settings.
        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 9))
                8:       topo = TOPO_GLOBAL;
                9:       topo = TOPO_GLOBAL + TOPO_W'($urandom_range(1, 3));
                default: topo = TOPO_W'($urandom_range(0, 3));
            endcase
            topo_word = PHASE_W'(topo);
            if ($urandom_range(0, 1))
                topo_word[PHASE_W-1:TOPO_W] = (PHASE_W - TOPO_W)'($urandom_range(0, 8191));
            load_settings(topo_word, pick_step());
            gaps_on    = ($urandom_range(0, 3) != 0);
            item_count = (topo == TOPO_GLOBAL) ? 6 : 18;
            for (int n = 0; n < item_count; n++)
            begin
                if ($urandom_range(0, 99) < 45)
                    issue_item(MODE_WRITE, pick_index(), pick_phase());
                else
                    issue_item(MODE_FIRE, pick_index(), pick_phase());
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[oscillator_neighbor_coupling_core.f]
+incdir+sv
sv/onc_pkg.sv
sv/onc_ctrl.sv
sv/onc_datapath.sv
sv/oscillator_neighbor_coupling_core.sv
tb/coupling_result_checker.sv
tb/oscillator_neighbor_coupling_core_test.sv
